[src/pme_pkg.sv]
`timescale 1ns / 1ps
package pme_pkg;

  localparam int MAX_NODES   = 32;
  localparam int MAX_EDGES   = 512;
  localparam int WEIGHT_BITS = 16;

  // fixed field widths of the channels
  localparam int NODE_W  = 5;
  localparam int WGT_W   = 16;
  localparam int NCNT_W  = 6;

  localparam int CNT_W   = $clog2(MAX_EDGES + 1);
  localparam int ADDR_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EDGE_W  = 2 * NODE_W + WEIGHT_BITS;
  localparam int VIS_W   = 1 << NODE_W;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [NCNT_W-1:0] NODE_CNT_RST = NCNT_W'(8);
  localparam logic [NCNT_W-1:0] NODE_CNT_MAX = NCNT_W'(MAX_NODES);

  // microprogram step addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] S_INIT  = 4'd1;
  localparam logic [PC_W-1:0] S_SSTRT = 4'd2;
  localparam logic [PC_W-1:0] S_SCAN  = 4'd3;
  localparam logic [PC_W-1:0] S_DRAIN = 4'd4;
  localparam logic [PC_W-1:0] S_CHECK = 4'd5;
  localparam logic [PC_W-1:0] S_TAKE  = 4'd6;
  localparam logic [PC_W-1:0] S_NEXT  = 4'd7;
  localparam logic [PC_W-1:0] S_FLUSH = 4'd8;
  localparam logic [PC_W-1:0] S_END   = 4'd9;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_LAST_IN,
    C_NO_ROUNDS,
    C_NO_EDGES,
    C_MORE_READS,
    C_NOT_FOUND,
    C_TAKE_STALL,
    C_MORE_ROUNDS,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic in_en;
    logic init;
    logic scan_clr;
    logic rd;
    logic take;
    logic flush;
  } act_t;

  typedef struct packed {
    act_t             act;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic last_in;
    logic no_rounds;
    logic no_edges;
    logic more_reads;
    logic not_found;
    logic take_stall;
    logic more_rounds;
    logic out_busy;
  } stat_t;

  localparam act_t A_NONE  = '{in_en: 1'b0, init: 1'b0, scan_clr: 1'b0,
                               rd: 1'b0, take: 1'b0, flush: 1'b0};

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{act: A_NONE, cond: C_NEVER, target: S_IDLE};
    unique case (pc)
      S_IDLE: begin
        w.act.in_en = 1'b1;
        w.cond      = C_NOT_LAST_IN;
        w.target    = S_IDLE;
      end
      S_INIT: begin
        w.act.init = 1'b1;
        w.cond     = C_NO_ROUNDS;
        w.target   = S_FLUSH;
      end
      S_SSTRT: begin
        w.act.scan_clr = 1'b1;
        w.cond         = C_NO_EDGES;
        w.target       = S_CHECK;
      end
      S_SCAN: begin
        w.act.rd = 1'b1;
        w.cond   = C_MORE_READS;
        w.target = S_SCAN;
      end
      S_DRAIN: begin
        w.cond   = C_NEVER;
      end
      S_CHECK: begin
        w.cond   = C_NOT_FOUND;
        w.target = S_FLUSH;
      end
      S_TAKE: begin
        w.act.take = 1'b1;
        w.cond     = C_TAKE_STALL;
        w.target   = S_TAKE;
      end
      S_NEXT: begin
        w.cond   = C_MORE_ROUNDS;
        w.target = S_SSTRT;
      end
      S_FLUSH: begin
        w.act.flush = 1'b1;
        w.cond      = C_OUT_BUSY;
        w.target    = S_FLUSH;
      end
      S_END: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[src/pme_if.sv]
`timescale 1ns / 1ps
interface pme_edge_if import pme_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] node_u;
  logic [NODE_W-1:0] node_v;
  logic [WGT_W-1:0]  edge_weight;
  logic              last_edge;

  modport source (output valid, node_u, node_v, edge_weight, last_edge, input ready);
  modport sink   (input valid, node_u, node_v, edge_weight, last_edge, output ready);
endinterface

interface pme_tree_if import pme_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] tree_u;
  logic [NODE_W-1:0] tree_v;
  logic [WGT_W-1:0]  tree_weight;
  logic              last_of_run;
  logic              empty_tree;
  logic              overflow;

  modport source (output valid, tree_u, tree_v, tree_weight, last_of_run, empty_tree,
                  overflow, input ready);
  modport sink   (input valid, tree_u, tree_v, tree_weight, last_of_run, empty_tree,
                  overflow, output ready);
endinterface

[src/pme_ram.sv]
`timescale 1ns / 1ps
module pme_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[src/pme_seq.sv]
`timescale 1ns / 1ps
module pme_seq import pme_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output act_t  act_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            jump;

  assign uw    = ucode(pc_q);
  assign act_o = uw.act;

  always_comb begin
    unique case (uw.cond)
      C_NEVER:       jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NOT_LAST_IN: jump = !stat_i.last_in;
      C_NO_ROUNDS:   jump = stat_i.no_rounds;
      C_NO_EDGES:    jump = stat_i.no_edges;
      C_MORE_READS:  jump = stat_i.more_reads;
      C_NOT_FOUND:   jump = stat_i.not_found;
      C_TAKE_STALL:  jump = stat_i.take_stall;
      C_MORE_ROUNDS: jump = stat_i.more_rounds;
      C_OUT_BUSY:    jump = stat_i.out_busy;
      default:       jump = 1'b1;
    endcase
    pc_d = jump ? uw.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

[src/pme_dp.sv]
`timescale 1ns / 1ps
module pme_dp import pme_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  act_t              act_i,
  output stat_t             stat_o,
  input  logic [NCNT_W-1:0] node_cnt_i,
  pme_edge_if.sink          edge_i,
  pme_tree_if.source        tree_o
);

  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   drop_q, drop_d;
  logic [VIS_W-1:0]       vis_q, vis_d;
  logic [NCNT_W-1:0]      rnd_q, rnd_d;
  logic [ADDR_W-1:0]      idx_q, idx_d;
  logic                   rd_vld_q;
  logic                   found_q, found_d;
  logic [NODE_W-1:0]      best_u_q, best_u_d, best_v_q, best_v_d;
  logic [WEIGHT_BITS-1:0] best_w_q, best_w_d;
  logic                   pend_q, pend_d;
  logic [NODE_W-1:0]      pend_u_q, pend_v_q;
  logic [WEIGHT_BITS-1:0] pend_w_q;
  logic                   ovld_q, ovld_d;
  logic [NODE_W-1:0]      ou_q, ov_q;
  logic [WGT_W-1:0]       ow_q;
  logic                   olast_q, oempty_q, oovf_q;

  logic                   in_acc, wr_en, out_free, take_go, flush_go, emit;
  logic [EDGE_W-1:0]      wdata, rdata;
  logic [NODE_W-1:0]      rd_u, rd_v;
  logic [WEIGHT_BITS-1:0] rd_w;
  logic [NCNT_W-1:0]      n_sat, rounds;
  logic                   cand;

  assign edge_i.ready = act_i.in_en;
  assign in_acc       = edge_i.valid && edge_i.ready;
  assign wr_en        = in_acc && (cnt_q < CNT_W'(MAX_EDGES));
  assign wdata        = {edge_i.node_u, edge_i.node_v, edge_i.edge_weight[WEIGHT_BITS-1:0]};

  pme_ram #(
    .Width(EDGE_W),
    .Depth(MAX_EDGES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(cnt_q[ADDR_W-1:0]),
    .wdata_i(wdata),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  assign {rd_u, rd_v, rd_w} = rdata;

  assign n_sat    = (node_cnt_i > NODE_CNT_MAX) ? NODE_CNT_MAX : node_cnt_i;
  assign rounds   = (n_sat == '0) ? '0 : n_sat - NCNT_W'(1);
  assign out_free = !ovld_q || tree_o.ready;
  assign take_go  = act_i.take && !(pend_q && !out_free);
  assign flush_go = act_i.flush && out_free;
  assign emit     = (take_go && pend_q) || flush_go;
  // exactly one visited end, and lighter than the best so far (ties keep the earlier)
  assign cand     = rd_vld_q && (vis_q[rd_u] != vis_q[rd_v]) && (!found_q || rd_w < best_w_q);

  always_comb begin
    stat_o.last_in     = in_acc && edge_i.last_edge;
    stat_o.no_rounds   = (rounds == '0);
    stat_o.no_edges    = (cnt_q == '0);
    stat_o.more_reads  = (CNT_W'(idx_q) != cnt_q - CNT_W'(1));
    stat_o.not_found   = !found_q;
    stat_o.take_stall  = pend_q && !out_free;
    stat_o.more_rounds = (rnd_q != '0);
    stat_o.out_busy    = !out_free;
  end

  always_comb begin
    cnt_d    = cnt_q;
    drop_d   = drop_q;
    vis_d    = vis_q;
    rnd_d    = rnd_q;
    idx_d    = idx_q;
    found_d  = found_q;
    best_u_d = best_u_q;
    best_v_d = best_v_q;
    best_w_d = best_w_q;
    pend_d   = pend_q;
    ovld_d   = ovld_q;

    if (in_acc) begin
      if (wr_en) begin
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        drop_d = 1'b1;
      end
    end
    if (act_i.init) begin
      vis_d  = VIS_W'(1);
      rnd_d  = rounds;
      pend_d = 1'b0;
    end
    if (act_i.scan_clr) begin
      idx_d   = '0;
      found_d = 1'b0;
    end
    if (act_i.rd) begin
      idx_d = idx_q + ADDR_W'(1);
    end
    if (cand) begin
      found_d  = 1'b1;
      best_u_d = rd_u;
      best_v_d = rd_v;
      best_w_d = rd_w;
    end
    if (take_go) begin
      pend_d = 1'b1;
      vis_d  = vis_q | (VIS_W'(1) << best_u_q) | (VIS_W'(1) << best_v_q);
      rnd_d  = rnd_q - NCNT_W'(1);
    end
    if (flush_go) begin
      pend_d = 1'b0;
      cnt_d  = '0;
      drop_d = 1'b0;
    end
    if (emit) begin
      ovld_d = 1'b1;
    end else if (tree_o.ready) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      drop_q   <= 1'b0;
      vis_q    <= '0;
      rnd_q    <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      pend_q   <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      drop_q   <= drop_d;
      vis_q    <= vis_d;
      rnd_q    <= rnd_d;
      idx_q    <= idx_d;
      rd_vld_q <= act_i.rd;
      found_q  <= found_d;
      pend_q   <= pend_d;
      ovld_q   <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_u_q <= best_u_d;
    best_v_q <= best_v_d;
    best_w_q <= best_w_d;
    if (take_go) begin
      pend_u_q <= best_u_q;
      pend_v_q <= best_v_q;
      pend_w_q <= best_w_q;
    end
    if (emit) begin
      // flush with nothing held back gives the empty-tree result
      ou_q     <= (flush_go && !pend_q) ? '0 : pend_u_q;
      ov_q     <= (flush_go && !pend_q) ? '0 : pend_v_q;
      ow_q     <= (flush_go && !pend_q) ? '0 : WGT_W'(pend_w_q);
      olast_q  <= flush_go;
      oempty_q <= flush_go && !pend_q;
      oovf_q   <= drop_q;
    end
  end

  assign tree_o.valid       = ovld_q;
  assign tree_o.tree_u      = ou_q;
  assign tree_o.tree_v      = ov_q;
  assign tree_o.tree_weight = ow_q;
  assign tree_o.last_of_run = olast_q;
  assign tree_o.empty_tree  = oempty_q;
  assign tree_o.overflow    = oovf_q;

endmodule

[src/prim_mst_edge_list.sv]
`timescale 1ns / 1ps
// Load: one edge request a cycle into the edge store, no results until the last edge.
// Compute: up to node_count-1 rounds, each a scan of the edge store (one store read a cycle);
//   a round that finds nothing ends the compute; the init, flush and end steps come on top.
// A chosen edge is held until the next choice or the flush, then shows in the cycle after;
//   a result still waiting in the output register stalls that step.
// Reset: async, active low; node_count returns to 8, the store needs no clearing pass.
module prim_mst_edge_list import pme_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  pme_edge_if.sink           edge_i,
  pme_tree_if.source         tree_o
);

  logic [NCNT_W-1:0] node_cnt_q;
  act_t              act;
  stat_t             stat;

  assign pready = 1'b1;
  assign prdata = paddr[PADDR_W-1] ? '0 : PDATA_W'(node_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_cnt_q <= NODE_CNT_RST;
    end else if (psel && penable && pwrite && !paddr[PADDR_W-1]) begin
      node_cnt_q <= pwdata[NCNT_W-1:0];
    end
  end

  pme_seq u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .act_o (act)
  );

  pme_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .act_i     (act),
    .stat_o    (stat),
    .node_cnt_i(node_cnt_q),
    .edge_i    (edge_i),
    .tree_o    (tree_o)
  );

endmodule

[src/pme_checker.sv]
`timescale 1ns / 1ps
module pme_checker import pme_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              pready,
  input logic              edge_valid,
  input logic              edge_ready,
  input logic              edge_last,
  input logic              tree_valid,
  input logic              tree_ready,
  input logic [NODE_W-1:0] tree_u,
  input logic [NODE_W-1:0] tree_v,
  input logic [WGT_W-1:0]  tree_weight,
  input logic              tree_last,
  input logic              tree_empty,
  input logic              tree_ovf
);

  // a pending result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tree_valid && !tree_ready |=> tree_valid &&
      $stable({tree_u, tree_v, tree_weight, tree_last, tree_empty, tree_ovf}))
    else $error("result changed while stalled");

  // the last edge closes the load phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_valid && edge_ready && edge_last |=> !edge_ready)
    else $error("edge request taken during compute");

  // an empty tree is a single zeroed closing result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tree_valid && tree_empty |->
      tree_last && tree_u == '0 && tree_v == '0 && tree_weight == '0)
    else $error("malformed empty result");

  // no edges are taken while results of a run are still being produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tree_valid && !tree_last |-> !edge_ready)
    else $error("load open during compute");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind prim_mst_edge_list pme_checker u_pme_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .pready     (pready),
  .edge_valid (edge_i.valid),
  .edge_ready (edge_i.ready),
  .edge_last  (edge_i.last_edge),
  .tree_valid (tree_o.valid),
  .tree_ready (tree_o.ready),
  .tree_u     (tree_o.tree_u),
  .tree_v     (tree_o.tree_v),
  .tree_weight(tree_o.tree_weight),
  .tree_last  (tree_o.last_of_run),
  .tree_empty (tree_o.empty_tree),
  .tree_ovf   (tree_o.overflow)
);
